// ===== hw/rtl/saturating_stereo_mix_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// Stereo mix buffer assertion macros
// Shared concurrent assertion forms for the mix buffer RTL.
// ----------------------------------------------------------------------------
`ifndef SATURATING_STEREO_MIX_BUFFER_DEFINES_SVH
`define SATURATING_STEREO_MIX_BUFFER_DEFINES_SVH

// Flag a condition that must never be seen at a clock edge.
`define SSMB_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

// Same-cycle implication.
`define SSMB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSMB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ssmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo mix buffer package
// Types, codes and saturating arithmetic shared by the mix buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssmb_pkg;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 9;
  localparam int PF_W       = 10;
  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int PROD_W     = 32;
  localparam int TAG_W      = 8;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MIX   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_STEREO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;

  // tag 0 marks a swept entry; live epochs run from TAG_FIRST to TAG_LAST
  localparam logic [TAG_W-1:0] TAG_EMPTY = '0;
  localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] TAG_LAST  = '1;

  typedef logic signed [SMP_W-1:0]  sample_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam sample_t SMP_MAX = 16'sh7FFF;
  localparam sample_t SMP_MIN = 16'sh8000;
  localparam sample_t SMP_ZERO = '0;
  localparam prod_t   TRUNC_BIAS = PROD_W'((1 << GAIN_FRAC) - 1);

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] frame_index;
    logic [PF_W-1:0]  period_frames;
    sample_t          clip_left;
    sample_t          clip_right;
    logic             clip_stereo;
  } item_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    sample_t          right;
    sample_t          left;
  } frame_word_t;

  typedef struct packed {
    logic [TAG_W-1:0]  epoch;
    logic [PF_W-1:0]   limit;
    logic              master_stereo;
    logic [GAIN_W-1:0] gain;
  } mix_ctrl_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
    logic    dropped;
  } result_t;

  // Add two samples and clamp to the int16 range.
  function automatic sample_t sat_add(input sample_t a, input sample_t b);
    logic [SMP_W:0] s;
    sample_t        r;
    s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
    if (s[SMP_W] != s[SMP_W-1]) begin
      r = s[SMP_W] ? SMP_MIN : SMP_MAX;
    end else begin
      r = s[SMP_W-1:0];
    end
    return r;
  endfunction

  // Divide a Q15 product by 2^15, truncating toward zero.
  function automatic sample_t scale_trunc(input prod_t p);
    prod_t adj;
    adj = p + (p[PROD_W-1] ? TRUNC_BIAS : '0);
    return adj[PROD_W-2:GAIN_FRAC];
  endfunction

endpackage

// ===== hw/rtl/ssmb_frame_ram.sv =====
// ----------------------------------------------------------------------------
// Frame memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssmb_frame_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  ssmb_pkg::frame_word_t  wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output ssmb_pkg::frame_word_t  rdata
);
  import ssmb_pkg::*;

  frame_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ssmb_epoch_ctrl.sv =====
// ----------------------------------------------------------------------------
// Epoch and configuration control
// Holds registers, period limit and epoch; sweeps the tags on reset and wrap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssmb_epoch_ctrl #(
  parameter int FRAMES = 512,
  parameter int AW     = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ssmb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssmb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              clear_go,
  input  logic [ssmb_pkg::PF_W-1:0]         clear_frames,
  output ssmb_pkg::mix_ctrl_t               ctrl,
  output logic                              sweeping,
  output logic [AW-1:0]                     sweep_addr
);
  import ssmb_pkg::*;

  localparam logic [AW-1:0] LastAddr = AW'(FRAMES - 1);

  logic [TAG_W-1:0]  epoch;
  logic [PF_W-1:0]   limit;
  logic              master_stereo;
  logic [GAIN_W-1:0] gain;
  logic [AW-1:0]     sweep_cnt;
  logic [PF_W-1:0]   limit_next;

  assign limit_next = (32'(clear_frames) < 32'(FRAMES)) ? clear_frames : PF_W'(FRAMES);

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch         <= TAG_FIRST;
      limit         <= '0;
      master_stereo <= 1'b1;
      gain          <= GAIN_RESET;
      sweeping      <= 1'b1;
      sweep_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MASTER_STEREO: master_stereo <= cfg_data[0];
          REG_GAIN:          gain <= (cfg_data > GAIN_MAX) ? GAIN_MAX : cfg_data;
          default: ;
        endcase
      end
      if (sweeping) begin
        sweep_cnt <= sweep_cnt + AW'(1);
        if (sweep_cnt == LastAddr) begin
          sweeping  <= 1'b0;
          sweep_cnt <= '0;
        end
      end
      if (clear_go) begin
        limit <= limit_next;
        // wrap the epoch back to the start and wipe stale tags
        if (epoch == TAG_LAST) begin
          epoch    <= TAG_FIRST;
          sweeping <= 1'b1;
        end else begin
          epoch <= epoch + TAG_W'(1);
        end
      end
    end
  end

  assign sweep_addr         = sweep_cnt;
  assign ctrl.epoch         = epoch;
  assign ctrl.limit         = limit;
  assign ctrl.master_stereo = master_stereo;
  assign ctrl.gain          = gain;

endmodule

// ===== hw/rtl/ssmb_mix_pipe.sv =====
// ----------------------------------------------------------------------------
// Mix pipeline
// Read-modify-write datapath: saturate, scale, write back, with bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "saturating_stereo_mix_buffer_defines.svh"

module ssmb_mix_pipe #(
  parameter int FRAMES = 512,
  parameter int AW     = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_go,
  input  ssmb_pkg::item_t               in_item,
  input  ssmb_pkg::mix_ctrl_t           ctrl,
  input  logic                          byp_clear,
  input  ssmb_pkg::frame_word_t         rdata,
  output logic                          hazard,
  output logic                          busy,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output ssmb_pkg::frame_word_t         wr_data,
  output logic                          res_valid,
  output ssmb_pkg::result_t             res
);
  import ssmb_pkg::*;

  // stage 1: memory data arrives
  logic             p1_valid, p1_mix, p1_drop, p1_in_range, p1_cst;
  logic [IDX_W-1:0] p1_idx;
  sample_t          p1_cl, p1_cr;
  // stage 2: saturated sums (or read values)
  logic             p2_valid, p2_mix, p2_drop, p2_cst;
  logic [IDX_W-1:0] p2_idx;
  sample_t          p2_sl, p2_sr;
  // stage 3: products
  logic             p3_valid, p3_mix, p3_drop, p3_cst;
  logic [IDX_W-1:0] p3_idx;
  prod_t            p3_pl, p3_pr;
  sample_t          p3_rl, p3_rr;
  // last write, forwarded over the write that lands with a read
  logic             byp_valid;
  logic [IDX_W-1:0] byp_idx;
  frame_word_t      byp_word;

  logic p1_wr, p2_wr, p3_wr;
  assign p1_wr = p1_mix && !p1_drop;
  assign p2_wr = p2_mix && !p2_drop;
  assign p3_wr = p3_mix && !p3_drop;

  assign busy = p1_valid || p2_valid || p3_valid;

  // hold a word that would read a frame whose new value is not yet computed
  assign hazard = (p1_valid && p1_wr && p1_idx == in_item.frame_index) ||
                  (p2_valid && p2_wr && p2_idx == in_item.frame_index);

  logic in_drop, in_range;
  assign in_drop  = ({1'b0, in_item.frame_index} >= ctrl.limit);
  assign in_range = 32'(in_item.frame_index) < 32'(FRAMES);

  // stage 1 logic
  frame_word_t word;
  logic        word_live;
  sample_t     ml, mr, sl, sr, rl, rr;

  always_comb begin
    word      = (byp_valid && byp_idx == p1_idx) ? byp_word : rdata;
    word_live = (word.tag == ctrl.epoch);
    ml        = word_live ? word.left : SMP_ZERO;
    mr        = word_live ? word.right : SMP_ZERO;
    sl        = sat_add(ml, p1_cl);
    sr        = sat_add(mr, p1_cr);
    rl        = p1_in_range ? ml : SMP_ZERO;
    rr        = (p1_in_range && ctrl.master_stereo) ? mr : SMP_ZERO;
  end

  // stage 2 logic
  logic signed [SMP_W+GAIN_W:0] full_l, full_r;
  assign full_l = p2_sl * $signed({1'b0, ctrl.gain});
  assign full_r = p2_sr * $signed({1'b0, ctrl.gain});

  // stage 3 logic
  sample_t ol, orr;
  always_comb begin
    ol = scale_trunc(p3_pl);
    if (!ctrl.master_stereo) begin
      orr = SMP_ZERO;
    end else if (p3_cst) begin
      orr = scale_trunc(p3_pr);
    end else begin
      orr = ol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= in_go;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mix      <= (in_item.command == CMD_MIX);
      p1_drop     <= (in_item.command == CMD_MIX) && in_drop;
      p1_in_range <= in_range;
      p1_cst      <= in_item.clip_stereo;
      p1_idx      <= in_item.frame_index;
      p1_cl       <= in_item.clip_left;
      p1_cr       <= in_item.clip_right;

      p2_mix  <= p1_mix;
      p2_drop <= p1_drop;
      p2_cst  <= p1_cst;
      p2_idx  <= p1_idx;
      p2_sl   <= p1_mix ? sl : rl;
      p2_sr   <= p1_mix ? sr : rr;

      p3_mix  <= p2_mix;
      p3_drop <= p2_drop;
      p3_cst  <= p2_cst;
      p3_idx  <= p2_idx;
      p3_pl   <= $signed(full_l[PROD_W-1:0]);
      p3_pr   <= $signed(full_r[PROD_W-1:0]);
      p3_rl   <= p2_sl;
      p3_rr   <= p2_sr;
    end
  end

  assign wr_en         = adv && p3_valid && p3_wr;
  assign wr_addr       = AW'(p3_idx);
  assign wr_data.tag   = ctrl.epoch;
  assign wr_data.right = orr;
  assign wr_data.left  = ol;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (byp_clear) begin
      byp_valid <= 1'b0;
    end else if (wr_en) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_idx  <= p3_idx;
      byp_word <= wr_data;
    end
  end

  always_comb begin
    res_valid = p3_valid;
    if (p3_drop) begin
      res.out_left  = SMP_ZERO;
      res.out_right = SMP_ZERO;
      res.dropped   = 1'b1;
    end else if (p3_mix) begin
      res.out_left  = ol;
      res.out_right = orr;
      res.dropped   = 1'b0;
    end else begin
      res.out_left  = p3_rl;
      res.out_right = p3_rr;
      res.dropped   = 1'b0;
    end
  end

  `SSMB_ASSERT_NEVER(a_no_raw_p2, clk, rst,
    p1_valid && p2_valid && p2_wr && p1_idx == p2_idx, "frame read ahead of pending mix")
  `SSMB_ASSERT_NEVER(a_no_raw_p3, clk, rst,
    p1_valid && p3_valid && p3_wr && p1_idx == p3_idx, "frame read two ahead of mix")
  `SSMB_ASSERT_NEXT(a_byp_tracks_write, clk, rst, wr_en,
    byp_valid && byp_idx == $past(p3_idx), "bypass lost the last write")

endmodule

// ===== hw/rtl/saturating_stereo_mix_buffer.sv =====
// ----------------------------------------------------------------------------
// Saturating stereo mix buffer
// Master frame buffer with epoch clear, saturating Q15 mix and frame read.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                    | contents
//  ----------+-----+------------------------------+---------------------------
//  s_axis    | in  | tvalid/tready                | command word
//  m_axis    | out | tvalid/tready                | mix or read result word
//  cfg       | in  | cfg_we (no wait, no readback)| register write
//
//  A mix or read word gives its result on m_axis after memory read,
//  saturating add, Q15 multiply and write back, in that order.
//  Throughput: one word per cycle while consecutive words hit different
//  frames; a word addressing a frame still in the two stages after the
//  memory read waits until the pending write reaches write-back.
//  A clear waits until the pipeline has drained.
//  Reset and every 255th clear run a tag sweep over the whole frame
//  memory with s_axis_tready low; cfg writes are taken throughout.
//  A full output register with m_axis_tready low stalls the whole pipeline
//  once a finished result waits in stage 3.
//
`timescale 1ns / 1ps
`include "saturating_stereo_mix_buffer_defines.svh"

module saturating_stereo_mix_buffer #(
  parameter int FRAMES = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  // frame_index[8:0], period_frames[18:9], clip_left[34:19],
  // clip_right[50:35], zero fill [55:51]
  input  logic [ssmb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command[1:0], clip_stereo[2]
  input  logic [ssmb_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // out_left[15:0], out_right[31:16]
  output logic [ssmb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // dropped[0]
  output logic [ssmb_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we,
  input  logic [ssmb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssmb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ssmb_pkg::*;

  localparam int AW = $clog2(FRAMES);

  item_t       in_item;
  mix_ctrl_t   ctrl;
  logic        sweeping;
  logic [AW-1:0] sweep_addr;
  logic        hazard, busy, adv;
  logic        in_go, clear_go, accept;
  logic        pipe_we;
  logic [AW-1:0] pipe_waddr;
  frame_word_t pipe_wdata, rdata, mem_wdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic        res_valid;
  result_t     res, out_res;
  logic        out_valid;
  logic        can_take;

  // unpack the input word
  assign in_item.command       = s_axis_tuser[1:0];
  assign in_item.clip_stereo   = s_axis_tuser[2];
  assign in_item.frame_index   = s_axis_tdata[8:0];
  assign in_item.period_frames = s_axis_tdata[18:9];
  assign in_item.clip_left     = s_axis_tdata[34:19];
  assign in_item.clip_right    = s_axis_tdata[50:35];

  // advance unless a finished result in stage 3 has nowhere to go
  assign adv = !res_valid || !out_valid || m_axis_tready;

  // clear needs a drained pipeline; mix and read must not race a pending write
  always_comb begin
    unique case (in_item.command) inside
      CMD_CLEAR:          can_take = !busy;
      CMD_MIX, CMD_READ:  can_take = !hazard;
      default:            can_take = 1'b1;
    endcase
  end

  assign s_axis_tready = adv && !sweeping && can_take;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_go         = accept &&
                         (in_item.command == CMD_MIX || in_item.command == CMD_READ);
  assign clear_go      = accept && (in_item.command == CMD_CLEAR);

  ssmb_epoch_ctrl #(
    .FRAMES (FRAMES),
    .AW     (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .clear_go     (clear_go),
    .clear_frames (in_item.period_frames),
    .ctrl         (ctrl),
    .sweeping     (sweeping),
    .sweep_addr   (sweep_addr)
  );

  ssmb_mix_pipe #(
    .FRAMES (FRAMES),
    .AW     (AW)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_go     (in_go),
    .in_item   (in_item),
    .ctrl      (ctrl),
    .byp_clear (clear_go),
    .rdata     (rdata),
    .hazard    (hazard),
    .busy      (busy),
    .wr_en     (pipe_we),
    .wr_addr   (pipe_waddr),
    .wr_data   (pipe_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // sweep writes an empty tag; it never overlaps pipeline write-back
  always_comb begin
    mem_we    = sweeping || pipe_we;
    mem_waddr = sweeping ? sweep_addr : pipe_waddr;
    if (sweeping) begin
      mem_wdata.tag   = TAG_EMPTY;
      mem_wdata.right = SMP_ZERO;
      mem_wdata.left  = SMP_ZERO;
    end else begin
      mem_wdata = pipe_wdata;
    end
  end

  ssmb_frame_ram #(
    .DEPTH (FRAMES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_go),
    .raddr (AW'(in_item.frame_index)),
    .rdata (rdata)
  );

  // output register: load from stage 3, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.out_right, out_res.out_left};
  assign m_axis_tuser  = out_res.dropped;

  `SSMB_ASSERT_NEVER(a_single_writer, clk, rst, sweeping && pipe_we,
    "sweep and write-back collide")
  `SSMB_ASSERT_IMPLY(a_sweep_from_clear, clk, rst, $rose(sweeping), $past(clear_go),
    "tag sweep started without a clear")
  `SSMB_ASSERT_IMPLY(a_out_from_pipe, clk, rst, $rose(m_axis_tvalid), $past(res_valid),
    "result word without a finished item")

endmodule

// ===== sim/saturating_stereo_mix_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating stereo mix buffer testbench
// Drives clear, mix, read and unused command words through the stream port,
// keeps a shadow of the frame buffer and its period state, and checks every
// result word field by field. Register settings change between phases only
// while the block is drained; sender and receiver stall at random.
// ----------------------------------------------------------------------------

module saturating_stereo_mix_buffer_tb;
  import ssmb_pkg::*;

  localparam int BUF_FRAMES   = 512;
  localparam int PHASES       = 9;
  localparam int PHASE_WORDS  = 192;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_LIMIT = 10;
  localparam int CYCLE_LIMIT  = 400000;

  // The block ignores this code; the package names only the three it uses.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // Per-phase register settings; a gain of -1 means pick one at random.
  int phase_gain [PHASES] = '{16384, 65535, 0, 32768, -1, 32769, -1, 32767, 1};
  bit phase_stereo [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [IN_USER_W-1:0]   s_axis_tuser = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [OUT_USER_W-1:0]  m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Stimulus and expectations
  item_t   pending_words [$];
  item_t   held_word;
  result_t expected_frames [$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      plan_limit = 0;   // generator's own view of the period length

  // Shadow of the block: register copies, frame buffer, live tags, period
  logic              stereo_reg = 1'b1;
  logic [GAIN_W-1:0] gain_reg = GAIN_RESET;
  sample_t           left_mem [BUF_FRAMES];
  sample_t           right_mem [BUF_FRAMES];
  bit                frame_live [BUF_FRAMES];
  logic [PF_W-1:0]   active_frames = '0;

  saturating_stereo_mix_buffer #(
    .FRAMES(BUF_FRAMES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Add a voice sample to a held one, clamp the wide sum to int16, then
  // scale by the gain (capped at unity) and truncate toward zero.
  function automatic sample_t scaled_mix(input sample_t held, input sample_t clip);
    int total;
    int gain;
    total = int'(held) + int'(clip);
    if (total > int'(SMP_MAX)) total = int'(SMP_MAX);
    if (total < int'(SMP_MIN)) total = int'(SMP_MIN);
    gain = (gain_reg > GAIN_MAX) ? int'(GAIN_MAX) : int'(gain_reg);
    return sample_t'((total * gain) / (1 << GAIN_FRAC));
  endfunction

  // Apply one accepted word to the shadow buffer and queue the result it
  // should produce. Clears and the unused command produce nothing.
  function automatic void advance_frame_model(input item_t w);
    result_t r;
    sample_t held_l;
    sample_t held_r;
    r = '0;
    case (w.command)
      CMD_CLEAR: begin
        // Flash clear: every frame reads as zero until mixed again.
        frame_live = '{default: 1'b0};
        active_frames = (w.period_frames > PF_W'(BUF_FRAMES)) ?
                        PF_W'(BUF_FRAMES) : w.period_frames;
      end
      CMD_MIX: begin
        if (PF_W'(w.frame_index) >= active_frames) begin
          // Beyond the period: state untouched, zeros with the drop flag.
          r.dropped = 1'b1;
        end else begin
          held_l = frame_live[w.frame_index] ? left_mem[w.frame_index] : SMP_ZERO;
          held_r = frame_live[w.frame_index] ? right_mem[w.frame_index] : SMP_ZERO;
          r.out_left = scaled_mix(held_l, w.clip_left);
          if (!stereo_reg) begin
            r.out_right = SMP_ZERO;
          end else if (w.clip_stereo) begin
            r.out_right = scaled_mix(held_r, w.clip_right);
          end else begin
            // Mono clip on a stereo master: right follows the mixed left.
            r.out_right = r.out_left;
          end
          left_mem[w.frame_index] = r.out_left;
          right_mem[w.frame_index] = r.out_right;
          frame_live[w.frame_index] = 1'b1;
        end
        expected_frames.push_back(r);
      end
      CMD_READ: begin
        // Reads ignore the period limit; stale frames read as zero.
        if (frame_live[w.frame_index]) begin
          r.out_left = left_mem[w.frame_index];
          r.out_right = stereo_reg ? right_mem[w.frame_index] : SMP_ZERO;
        end
        expected_frames.push_back(r);
      end
      default: begin
        // Unused command: drop silently.
      end
    endcase
  endfunction

  function automatic item_t make_word(input logic [CMD_W-1:0] cmd,
                                      input int idx, input int pf,
                                      input int cl, input int cr, input bit cst);
    item_t w;
    w.command = cmd;
    w.frame_index = IDX_W'(idx);
    w.period_frames = PF_W'(pf);
    w.clip_left = sample_t'(cl);
    w.clip_right = sample_t'(cr);
    w.clip_stereo = cst;
    return w;
  endfunction

  // Extremes a fifth of the time, zero or -1 another fifth, otherwise any 16-bit pattern.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SMP_ZERO;
      3: return sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Mostly inside the current period, often a handful of hot frames so that
  // back-to-back words hit the same frame; sometimes the boundary or anywhere.
  function automatic logic [IDX_W-1:0] pick_frame();
    int r;
    int hot;
    r = $urandom_range(0, 99);
    hot = (plan_limit < 6) ? plan_limit : 6;
    if (plan_limit == 0 || r < 12) return IDX_W'($urandom_range(0, BUF_FRAMES - 1));
    if (r < 18 && plan_limit < BUF_FRAMES) return IDX_W'(plan_limit);
    if (r < 60) return IDX_W'($urandom_range(0, hot - 1));
    return IDX_W'($urandom_range(0, plan_limit - 1));
  endfunction

  task automatic push_random_word(input int clear_pct);
    item_t w;
    int    roll;
    roll = $urandom_range(0, 99);
    w.frame_index = pick_frame();
    w.period_frames = PF_W'($urandom_range(0, 1023));
    w.clip_left = pick_sample();
    w.clip_right = pick_sample();
    w.clip_stereo = 1'($urandom_range(0, 1));
    if (roll < clear_pct) begin
      w.command = CMD_CLEAR;
      case ($urandom_range(0, 9))
        0: w.period_frames = '0;
        1: w.period_frames = PF_W'(BUF_FRAMES);
        2: w.period_frames = PF_W'($urandom_range(BUF_FRAMES + 1, 1023));
        3: w.period_frames = PF_W'($urandom_range(0, 1023));
        default: w.period_frames = PF_W'($urandom_range(1, 48));
      endcase
      plan_limit = (w.period_frames > BUF_FRAMES) ? BUF_FRAMES : int'(w.period_frames);
    end else if (roll < clear_pct + 4) begin
      w.command = CMD_NONE;
    end else if (roll < clear_pct + 32) begin
      w.command = CMD_READ;
    end else begin
      w.command = CMD_MIX;
    end
    pending_words.push_back(w);
  endtask

  // Register writes are posted: one cycle with the enable high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MASTER_STEREO) stereo_reg = val[0];
    else gain_reg = val;
  endtask

  // Hold until every word is sent and every result is back, then let the
  // pipeline settle so a trailing clear has surely landed. Sample between
  // edges so the driver and monitor updates of the same edge are visible.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || expected_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stall pattern: sender light / receiver heavy, then reversed, then none.
  task automatic pick_idle_mode(input int k);
    case (k % 3)
      0: begin send_idle_pct = 21; recv_idle_pct = 69; end
      1: begin send_idle_pct = 69; recv_idle_pct = 21; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // Driver: a word moves when tvalid and tready meet at an edge. Only then,
  // or when nothing is offered, load the next word or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) advance_frame_model(held_word);
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        held_word = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, held_word.clip_right, held_word.clip_left,
                         held_word.period_frames, held_word.frame_index};
        s_axis_tuser <= {held_word.clip_stereo, held_word.command};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: toggle tready at random and compare each result word with the
  // oldest expectation.
  always @(posedge clk) begin : result_monitor
    result_t seen;
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.out_left = m_axis_tdata[15:0];
        seen.out_right = m_axis_tdata[31:16];
        seen.dropped = m_axis_tuser[0];
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result word with nothing pending: L=%0d R=%0d drop=%0b",
                     $realtime, seen.out_left, seen.out_right, seen.dropped);
        end else begin
          want = expected_frames.pop_front();
          if (seen.out_left !== want.out_left || seen.out_right !== want.out_right ||
              seen.dropped !== want.dropped) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: result word expected L=%0d R=%0d drop=%0b, got L=%0d R=%0d drop=%0b",
                       $realtime, want.out_left, want.out_right, want.dropped,
                       seen.out_left, seen.out_right, seen.dropped);
          end
        end
      end
    end
  end

  // Watchdog: covers stalls, the clearing passes and every drain pause.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int g;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: stereo master at unity gain.
    pick_idle_mode(0);
    write_reg(REG_MASTER_STEREO, CFG_DATA_W'(1));
    write_reg(REG_GAIN, GAIN_MAX);
    // Period limit is zero after reset: drop the mix, read zeros.
    pending_words.push_back(make_word(CMD_MIX, 0, 0, 100, 100, 1'b1));
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 1'b0));
    pending_words.push_back(make_word(CMD_NONE, 511, 1023, -1, -1, 1'b1));
    // Oversized period clamps to the whole buffer.
    pending_words.push_back(make_word(CMD_CLEAR, 0, 1023, 0, 0, 1'b0));
    pending_words.push_back(make_word(CMD_MIX, 511, 0, 32767, -32768, 1'b1));
    pending_words.push_back(make_word(CMD_MIX, 511, 0, 32767, -32768, 1'b1));
    pending_words.push_back(make_word(CMD_READ, 511, 0, 0, 0, 1'b0));
    // Mono clip on stereo master, then saturate low.
    pending_words.push_back(make_word(CMD_MIX, 0, 0, -32768, 12345, 1'b0));
    pending_words.push_back(make_word(CMD_MIX, 0, 0, -1, 0, 1'b0));
    pending_words.push_back(make_word(CMD_READ, 0, 0, 0, 0, 1'b0));
    // Short period: stale frame reads zero, boundary mix drops, hazards.
    pending_words.push_back(make_word(CMD_CLEAR, 0, 3, 0, 0, 1'b0));
    pending_words.push_back(make_word(CMD_READ, 511, 0, 0, 0, 1'b0));
    pending_words.push_back(make_word(CMD_MIX, 3, 0, 7, 7, 1'b1));
    pending_words.push_back(make_word(CMD_MIX, 2, 0, 1000, -1000, 1'b1));
    pending_words.push_back(make_word(CMD_READ, 2, 0, 0, 0, 1'b0));
    pending_words.push_back(make_word(CMD_MIX, 2, 0, -500, 500, 1'b1));
    pending_words.push_back(make_word(CMD_MIX, 2, 0, 20000, 20000, 1'b1));
    pending_words.push_back(make_word(CMD_READ, 1, 0, 0, 0, 1'b0));
    pending_words.push_back(make_word(CMD_CLEAR, 0, 512, 0, 0, 1'b0));
    pending_words.push_back(make_word(CMD_MIX, 511, 0, 5, -5, 1'b1));
    pending_words.push_back(make_word(CMD_READ, 2, 0, 0, 0, 1'b0));
    // Empty period: everything drops, reads still answer.
    pending_words.push_back(make_word(CMD_CLEAR, 0, 0, 0, 0, 1'b0));
    pending_words.push_back(make_word(CMD_MIX, 0, 0, 1, 1, 1'b1));
    pending_words.push_back(make_word(CMD_READ, 511, 0, 0, 0, 1'b0));
    plan_limit = 0;
    wait_drained();

    // Random phases, each under its own register setting and stall pattern.
    // Phase four is clear heavy so the periodic tag sweep gets exercised.
    for (int p = 0; p < PHASES; p++) begin
      pick_idle_mode(p + 1);
      g = (phase_gain[p] < 0) ? $urandom_range(0, 65535) : phase_gain[p];
      write_reg(REG_MASTER_STEREO, CFG_DATA_W'(phase_stereo[p]));
      write_reg(REG_GAIN, CFG_DATA_W'(g));
      repeat (PHASE_WORDS) push_random_word((p == 4) ? 45 : 12);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
